FILE: sv/vrdma_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the video RAM DMA controller.
package vrdma_pkg;

    typedef enum logic [2:0] {
        REQ_WRITE     = 3'd0,
        REQ_READ_LEN  = 3'd1,
        REQ_HBL_START = 3'd2,
        REQ_HBL_END   = 3'd3,
        REQ_TICK      = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_GENERAL = 2'd1,
        MODE_HBLANK  = 2'd2
    } t_mode;

    localparam logic [7:0] OFF_OAM_DMA  = 8'h46;
    localparam logic [7:0] OFF_SRC_HI   = 8'h51;
    localparam logic [7:0] OFF_SRC_LO   = 8'h52;
    localparam logic [7:0] OFF_DST_HI   = 8'h53;
    localparam logic [7:0] OFF_DST_LO   = 8'h54;
    localparam logic [7:0] OFF_LEN_CTRL = 8'h55;

    localparam logic [15:0] OAM_BASE       = 16'hfe00;
    localparam logic [11:0] OAM_BYTES      = 12'd160;
    localparam logic [11:0] BLOCK_BYTES    = 12'd16;
    localparam logic [15:0] POINTER_STEP   = 16'h0010;
    localparam logic [7:0]  LEN_ACTIVE_BIT = 8'h80;

    typedef struct packed {
        logic        copy_valid;
        logic [15:0] copy_source;
        logic [15:0] copy_target;
        logic [11:0] copy_bytes;
        logic [7:0]  status_byte;
    } t_result;

endpackage

FILE: sv/vrdma_out_buf.sv
`timescale 1ns / 1ps
// Two-entry output buffer that decouples result delivery from input acceptance.
module vrdma_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vrdma_pkg::t_result i_data,
    output logic              o_can_push,
    output logic              o_valid,
    input  logic              i_ready,
    output vrdma_pkg::t_result o_data
);
    import vrdma_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop        = r_main_valid && i_ready;
    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_data     = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= i_push;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (!r_main_valid) begin
            r_main_valid <= i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end else if (!r_main_valid) begin
            r_main <= i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

FILE: sv/video_ram_dma_controller_core.sv
`timescale 1ns / 1ps
// Top level of the video RAM DMA controller: register state, command logic and output buffer.
// The controller takes one word per cycle and returns exactly one result word for each,
// at the earliest in the cycle after it is accepted: the register state and the command are
// worked out in the cycle a word is accepted, and the result lands in a two-entry output buffer,
// so input words keep flowing while one result waits to be taken. Input ready drops only when
// both buffer entries are full. There is no clearing pass after reset.
module video_ram_dma_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_reg_offset,
    input  logic [7:0]  i_write_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_copy_valid,
    output logic [15:0] o_copy_source,
    output logic [15:0] o_copy_target,
    output logic [11:0] o_copy_bytes,
    output logic [7:0]  o_status_byte
);
    import vrdma_pkg::*;

    logic [15:0] r_source_pointer, n_source_pointer;
    logic [15:0] r_target_pointer, n_target_pointer;
    logic [7:0]  r_length_reg,     n_length_reg;
    t_mode       r_transfer_mode,  n_transfer_mode;
    logic        r_in_blank,       n_in_blank;
    logic        r_line_done,      n_line_done;

    t_result result;
    t_result out_data;
    logic    accept;
    logic    can_push;

    assign accept     = i_in_valid && can_push;
    assign o_in_ready = can_push;

    always_comb begin
        n_source_pointer = r_source_pointer;
        n_target_pointer = r_target_pointer;
        n_length_reg     = r_length_reg;
        n_transfer_mode  = r_transfer_mode;
        n_in_blank       = r_in_blank;
        n_line_done      = r_line_done;
        result           = '0;

        case (t_req'(i_req_type))
            REQ_WRITE: begin
                case (i_reg_offset)
                    OFF_OAM_DMA: begin
                        result.copy_valid  = 1'b1;
                        result.copy_source = {i_write_value, 8'h00};
                        result.copy_target = OAM_BASE;
                        result.copy_bytes  = OAM_BYTES;
                    end
                    OFF_SRC_HI: n_source_pointer = {i_write_value, r_source_pointer[7:0]};
                    OFF_SRC_LO: n_source_pointer = {r_source_pointer[15:8], i_write_value};
                    OFF_DST_HI: n_target_pointer = {i_write_value, r_target_pointer[7:0]};
                    OFF_DST_LO: n_target_pointer = {r_target_pointer[15:8], i_write_value};
                    OFF_LEN_CTRL: begin
                        n_transfer_mode = i_write_value[7] ? MODE_HBLANK : MODE_GENERAL;
                        n_length_reg    = i_write_value | LEN_ACTIVE_BIT;
                    end
                    default: ;
                endcase
            end
            REQ_READ_LEN: result.status_byte = r_length_reg;
            REQ_HBL_START: begin
                n_line_done = 1'b0;
                n_in_blank  = 1'b1;
            end
            REQ_HBL_END: n_in_blank = 1'b0;
            REQ_TICK: begin
                if (r_length_reg[7]) begin
                    if (r_transfer_mode == MODE_GENERAL) begin
                        result.copy_valid  = 1'b1;
                        result.copy_source = r_source_pointer;
                        result.copy_target = r_target_pointer;
                        result.copy_bytes  = ({5'd0, r_length_reg[6:0]} + 12'd1) << 4;
                        n_length_reg       = '0;
                        n_transfer_mode    = MODE_NONE;
                    end else if (r_transfer_mode == MODE_HBLANK && r_in_blank
                                 && !r_line_done) begin
                        result.copy_valid  = 1'b1;
                        result.copy_source = r_source_pointer;
                        result.copy_target = r_target_pointer;
                        result.copy_bytes  = BLOCK_BYTES;
                        n_source_pointer   = r_source_pointer + POINTER_STEP;
                        n_target_pointer   = r_target_pointer + POINTER_STEP;
                        if (r_length_reg[6:0] == 7'd0) begin
                            n_length_reg    = '0;
                            n_transfer_mode = MODE_NONE;
                        end else begin
                            n_length_reg = r_length_reg - 8'd1;
                        end
                        n_line_done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_pointer <= '0;
            r_target_pointer <= '0;
            r_length_reg     <= '0;
            r_transfer_mode  <= MODE_NONE;
            r_in_blank       <= 1'b0;
            r_line_done      <= 1'b0;
        end else if (accept) begin
            r_source_pointer <= n_source_pointer;
            r_target_pointer <= n_target_pointer;
            r_length_reg     <= n_length_reg;
            r_transfer_mode  <= n_transfer_mode;
            r_in_blank       <= n_in_blank;
            r_line_done      <= n_line_done;
        end
    end

    vrdma_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_data     (result),
        .o_can_push (can_push),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (out_data)
    );

    assign o_copy_valid  = out_data.copy_valid;
    assign o_copy_source = out_data.copy_source;
    assign o_copy_target = out_data.copy_target;
    assign o_copy_bytes  = out_data.copy_bytes;
    assign o_status_byte = out_data.status_byte;

endmodule

FILE: sv/vrdma_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the video RAM DMA controller and its bind to the top level.
module vrdma_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [2:0]  i_req_type,
    input logic [7:0]  i_reg_offset,
    input logic [7:0]  i_write_value,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_copy_valid,
    input logic [15:0] o_copy_source,
    input logic [15:0] o_copy_target,
    input logic [11:0] o_copy_bytes,
    input logic [7:0]  o_status_byte
);

    // No result word may appear in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid)
        else $error("result word present right after reset");

    // A stalled result word keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_copy_valid)
        && $stable(o_copy_source) && $stable(o_copy_target)
        && $stable(o_copy_bytes) && $stable(o_status_byte))
        else $error("stalled result word changed");

    // Without a copy command the address and length fields are zero.
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_copy_valid |-> o_copy_source == 16'd0
        && o_copy_target == 16'd0 && o_copy_bytes == 12'd0)
        else $error("copy fields set without a copy command");

    // A copy command carries a nonzero multiple of 16 bytes and no status byte.
    a_copy_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_copy_valid |-> o_copy_bytes[3:0] == 4'd0
        && o_copy_bytes != 12'd0 && o_status_byte == 8'd0)
        else $error("malformed copy command");

endmodule

bind video_ram_dma_controller_core vrdma_checker u_vrdma_checker (.*);
